### hdl/tcb_pkg.sv
// shared types and constants for the text cell buffer
`default_nettype none

package tcb_pkg;

  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] HASH_CODE  = 8'h23;

  // register reset values
  localparam logic [6:0] RST_ACTIVE_WIDTH  = 7'd64;
  localparam logic [5:0] RST_ACTIVE_HEIGHT = 6'd32;
  localparam logic [7:0] RST_COLOR         = 8'd7;

  // register indexes
  localparam logic [1:0] CFG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_ACTIVE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_COLOR = 2'd2;

  // command modes
  localparam logic [2:0] MODE_CLEAR  = 3'd0;
  localparam logic [2:0] MODE_DRAW   = 3'd1;
  localparam logic [2:0] MODE_BORDER = 3'd2;
  localparam logic [2:0] MODE_RENDER = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  // result kinds
  localparam logic KIND_CHANGE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [2:0] {
    SEL_ITEM  = 3'd0,
    SEL_TOP   = 3'd1,
    SEL_BOT   = 3'd2,
    SEL_LEFT  = 3'd3,
    SEL_RIGHT = 3'd4,
    SEL_ROW   = 3'd5
  } coord_sel_e;

  typedef struct packed {
    logic       item_load;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       sweep_wr;
    logic       sweep_init;
    logic       put_wr;
    coord_sel_e sel;
    logic       rd_en;
    logic       push;
    logic       flush;
    logic       rd_out;
  } tcb_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       sweep_end;
    logic       edge_w_end;
    logic       edge_h_end;
    logic       row_end;
    logic       row_ok;
    logic       box_ok;
    logic       differ;
    logic       pend_valid;
    logic       out_free;
  } tcb_status_t;

endpackage

`default_nettype wire

### hdl/tcb_dp.sv
// datapath: grid memories, item and config registers, pending cell and output register
`default_nettype none

module tcb_dp #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tcb_pkg::tcb_cmd_t    cmd_i,
  output tcb_pkg::tcb_status_t      status_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic [2:0]           mode_i,
  input  wire logic signed [9:0]    pos_x_i,
  input  wire logic signed [9:0]    pos_y_i,
  input  wire logic [7:0]           glyph_i,
  input  wire logic [7:0]           color_i,
  input  wire logic [8:0]           box_width_i,
  input  wire logic [8:0]           box_height_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      kind_o,
  output logic [5:0]                cell_x_o,
  output logic [4:0]                cell_y_o,
  output logic [7:0]                cell_glyph_o,
  output logic [7:0]                cell_color_o,
  output logic                      last_o
);
  import tcb_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = (AW > 9) ? AW : 9;

  // configuration
  logic [6:0] active_width_q;
  logic [5:0] active_height_q;
  logic [7:0] default_color_q;
  logic       cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_width_q  <= RST_ACTIVE_WIDTH;
      active_height_q <= RST_ACTIVE_HEIGHT;
      default_color_q <= RST_COLOR;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_ACTIVE_WIDTH:  active_width_q  <= cfg_data_i[6:0];
        CFG_ACTIVE_HEIGHT: active_height_q <= cfg_data_i[5:0];
        CFG_DEFAULT_COLOR: default_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [6:0] eff_w;
  logic [8:0] eff_h;

  assign eff_w = (active_width_q > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : active_width_q;
  assign eff_h = ({3'b000, active_height_q} > 9'(MAX_HEIGHT)) ?
                 9'(MAX_HEIGHT) : {3'b000, active_height_q};

  // captured item
  logic [2:0] mode_q;
  logic [9:0] px_q;
  logic [9:0] py_q;
  logic [7:0] glyph_q;
  logic [7:0] color_q;
  logic [8:0] bw_q;
  logic [8:0] bh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      mode_q  <= mode_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      glyph_q <= glyph_i;
      color_q <= color_i;
      bw_q    <= box_width_i;
      bh_q    <= box_height_i;
    end
  end

  // walk counter: sweep address, border step or row column
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // coordinates, 12-bit two's complement
  logic [11:0] px_s, py_s, step_s, bw_s, bh_s;
  logic [11:0] cx, cy;

  assign px_s   = {{2{px_q[9]}}, px_q};
  assign py_s   = {{2{py_q[9]}}, py_q};
  assign step_s = {3'b000, cnt_q[8:0]};
  assign bw_s   = {3'b000, bw_q};
  assign bh_s   = {3'b000, bh_q};

  always_comb begin
    unique case (cmd_i.sel)
      SEL_ITEM: begin
        cx = px_s;
        cy = py_s;
      end
      SEL_TOP: begin
        cx = px_s + step_s;
        cy = py_s;
      end
      SEL_BOT: begin
        cx = px_s + step_s;
        cy = py_s + bh_s - 12'd1;
      end
      SEL_LEFT: begin
        cx = px_s;
        cy = py_s + step_s;
      end
      SEL_RIGHT: begin
        cx = px_s + bw_s - 12'd1;
        cy = py_s + step_s;
      end
      SEL_ROW: begin
        cx = step_s;
        cy = py_s;
      end
      default: begin
        cx = px_s;
        cy = py_s;
      end
    endcase
  end

  logic          on_grid;
  logic [AW-1:0] addr;

  assign on_grid = !cx[11] && !cy[11] && (cx < {5'b00000, eff_w}) &&
                   (cy < {3'b000, eff_h});
  assign addr    = AW'(cy[YW-1:0]) * AW'(MAX_WIDTH) + AW'(cx[XW-1:0]);

  // grid memories, {glyph, color} per entry
  logic [15:0] back_mem  [CELLS];
  logic [15:0] shown_mem [CELLS];
  logic [15:0] back_rd_q, shown_rd_q;

  logic          back_we, shown_we, rd_go;
  logic [AW-1:0] waddr;
  logic [15:0]   back_wdata, shown_wdata;

  assign back_we  = cmd_i.sweep_wr || (cmd_i.put_wr && on_grid);
  assign shown_we = (cmd_i.sweep_wr && cmd_i.sweep_init) || cmd_i.push;
  assign waddr    = cmd_i.sweep_wr ? cnt_q[AW-1:0] : addr;
  assign rd_go    = cmd_i.rd_en && on_grid;

  always_comb begin
    if (cmd_i.sweep_wr) begin
      back_wdata = {SPACE_CODE, cmd_i.sweep_init ? RST_COLOR : default_color_q};
    end else if (cmd_i.sel == SEL_ITEM) begin
      back_wdata = {glyph_q, color_q};
    end else begin
      back_wdata = {HASH_CODE, default_color_q};
    end
  end

  assign shown_wdata = cmd_i.push ? back_rd_q : {SPACE_CODE, RST_COLOR};

  always_ff @(posedge clk_i) begin
    if (back_we) begin
      back_mem[waddr] <= back_wdata;
    end
    if (rd_go) begin
      back_rd_q <= back_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shown_we) begin
      shown_mem[waddr] <= shown_wdata;
    end
    if (rd_go) begin
      shown_rd_q <= shown_mem[addr];
    end
  end

  // pending changed cell, held back until we know whether it is the last one
  logic        pend_valid_q, pend_valid_d;
  logic [5:0]  pend_x_q;
  logic [15:0] pend_cell_q;

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (cmd_i.push) begin
      pend_valid_d = 1'b1;
    end else if (cmd_i.flush) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      pend_x_q    <= cnt_q[5:0];
      pend_cell_q <= back_rd_q;
    end
  end

  // output register
  logic        out_valid_q, out_valid_d;
  logic        out_load, pend_out;
  logic        kind_q, last_q;
  logic [5:0]  x_q;
  logic [4:0]  y_q;
  logic [15:0] cell_q;

  assign pend_out = (cmd_i.push && pend_valid_q) || cmd_i.flush;
  assign out_load = pend_out || cmd_i.rd_out;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_out) begin
      kind_q <= KIND_CHANGE;
      x_q    <= pend_x_q;
      y_q    <= py_q[4:0];
      cell_q <= pend_cell_q;
      last_q <= cmd_i.flush;
    end else if (cmd_i.rd_out) begin
      kind_q <= KIND_READ;
      x_q    <= '0;
      y_q    <= '0;
      cell_q <= on_grid ? back_rd_q : {SPACE_CODE, default_color_q};
      last_q <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign cell_x_o     = x_q;
  assign cell_y_o     = y_q;
  assign cell_glyph_o = cell_q[15:8];
  assign cell_color_o = cell_q[7:0];
  assign last_o       = last_q;

  // status to the controller
  assign status_o.mode       = mode_q;
  assign status_o.sweep_end  = (cnt_q == CW'(CELLS - 1));
  assign status_o.edge_w_end = (cnt_q[8:0] == bw_q - 9'd1);
  assign status_o.edge_h_end = (cnt_q[8:0] == bh_q - 9'd1);
  assign status_o.row_end    = (cnt_q[8:0] == {2'b00, eff_w} - 9'd1);
  assign status_o.row_ok     = !py_q[9] && (py_q < {1'b0, eff_h}) && (eff_w != 7'd0);
  assign status_o.box_ok     = (bw_q != 9'd0) && (bh_q != 9'd0);
  assign status_o.differ     = (back_rd_q != shown_rd_q);
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("result loaded over a stalled beat");

  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_wr |-> (cnt_q <= CW'(CELLS - 1)))
    else $error("sweep address beyond grid");
`endif

endmodule

`default_nettype wire

### hdl/tcb_ctrl.sv
// controller: sequences clear, draw, border walk, row render and read
`default_nettype none

module tcb_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output tcb_pkg::tcb_cmd_t         cmd_o,
  input  wire tcb_pkg::tcb_status_t status_i
);
  import tcb_pkg::*;

  typedef enum logic [13:0] {
    S_INIT   = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_DECODE = 14'b00000000000100,
    S_CLEAR  = 14'b00000000001000,
    S_DRAW   = 14'b00000000010000,
    S_BTOP   = 14'b00000000100000,
    S_BBOT   = 14'b00000001000000,
    S_BLEFT  = 14'b00000010000000,
    S_BRIGHT = 14'b00000100000000,
    S_RRD    = 14'b00001000000000,
    S_RCMP   = 14'b00010000000000,
    S_RFLUSH = 14'b00100000000000,
    S_RDRD   = 14'b01000000000000,
    S_RDOUT  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o     = '0;
    cmd_o.sel = SEL_ITEM;
    state_d   = state_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_wr   = 1'b1;
        cmd_o.sweep_init = 1'b1;
        if (status_i.sweep_end) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          cmd_o.cnt_clr   = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.mode)
          MODE_CLEAR:  state_d = S_CLEAR;
          MODE_DRAW:   state_d = S_DRAW;
          MODE_BORDER: state_d = status_i.box_ok ? S_BTOP : S_IDLE;
          MODE_RENDER: state_d = status_i.row_ok ? S_RRD : S_IDLE;
          MODE_READ:   state_d = S_RDRD;
          default:     state_d = S_IDLE;
        endcase
      end
      S_CLEAR: begin
        cmd_o.sweep_wr = 1'b1;
        if (status_i.sweep_end) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_DRAW: begin
        cmd_o.put_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_BTOP: begin
        cmd_o.put_wr = 1'b1;
        cmd_o.sel    = SEL_TOP;
        if (status_i.edge_w_end) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_BBOT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_BBOT: begin
        cmd_o.put_wr = 1'b1;
        cmd_o.sel    = SEL_BOT;
        if (status_i.edge_w_end) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_BLEFT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_BLEFT: begin
        cmd_o.put_wr = 1'b1;
        cmd_o.sel    = SEL_LEFT;
        if (status_i.edge_h_end) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_BRIGHT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_BRIGHT: begin
        cmd_o.put_wr = 1'b1;
        cmd_o.sel    = SEL_RIGHT;
        if (status_i.edge_h_end) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_RRD: begin
        cmd_o.sel   = SEL_ROW;
        cmd_o.rd_en = 1'b1;
        state_d     = S_RCMP;
      end
      S_RCMP: begin
        cmd_o.sel = SEL_ROW;
        // a new change can only move the pending one out if the output has room
        if (!status_i.differ || !status_i.pend_valid || status_i.out_free) begin
          cmd_o.push = status_i.differ;
          if (status_i.row_end) begin
            state_d = S_RFLUSH;
          end else begin
            cmd_o.cnt_inc = 1'b1;
            state_d       = S_RRD;
          end
        end
      end
      S_RFLUSH: begin
        if (!status_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RDRD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RDOUT;
      end
      S_RDOUT: begin
        if (status_i.out_free) begin
          cmd_o.rd_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push && status_i.pend_valid) |-> status_i.out_free)
    else $error("pending cell pushed into a full output");

  a_flush_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flush |-> (status_i.pend_valid && status_i.out_free))
    else $error("flush without a pending cell or room");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DECODE))
    else $error("accepted beat not decoded");
`endif

endmodule

`default_nettype wire

### hdl/text_cell_buffer_with_diff_flush.sv
// top level of the double-buffered text cell buffer
`default_nettype none

// Back and front grids of MAX_WIDTH x MAX_HEIGHT cells (glyph and color), each in a
// single-port-write memory with a registered read. After reset the block runs a
// clearing pass over every cell before it takes the first command. One command is
// worked at a time, one cell access per cycle while the output is not stalled:
// clear sweeps the back grid, draw writes one cell, read fetches one cell, border
// walks the top, bottom, left and right edges and render row compares each column
// of the active width; an empty box, a row off the grid and an unused mode return
// to idle without work. A render row returns its changed cells in column order with
// last on the final one; a row with no change returns nothing. Reads always return
// one beat. Register writes are taken at any time but belong between commands.
module text_cell_buffer_with_diff_flush #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [7:0]        cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        mode_i,
  input  wire logic signed [9:0] pos_x_i,
  input  wire logic signed [9:0] pos_y_i,
  input  wire logic [7:0]        glyph_i,
  input  wire logic [7:0]        color_i,
  input  wire logic [8:0]        box_width_i,
  input  wire logic [8:0]        box_height_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   kind_o,
  output logic [5:0]             cell_x_o,
  output logic [4:0]             cell_y_o,
  output logic [7:0]             cell_glyph_o,
  output logic [7:0]             cell_color_o,
  output logic                   last_o
);
  import tcb_pkg::*;

  tcb_cmd_t    cmd;
  tcb_status_t status;

  tcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  tcb_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (mode_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .glyph_i      (glyph_i),
    .color_i      (color_i),
    .box_width_i  (box_width_i),
    .box_height_i (box_height_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .cell_x_o     (cell_x_o),
    .cell_y_o     (cell_y_o),
    .cell_glyph_o (cell_glyph_o),
    .cell_color_o (cell_color_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire
